// File: src/multilevel_queue_scheduler_assert.svh
// assertion macros for the multilevel queue scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define MQS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define MQS_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MQS_ASSERT(label, clk, rst, prop)
`define MQS_ASSERT_R(label, clk, prop)
`endif
`endif

// File: src/mqs_pkg.sv
// shared types and constants of the multilevel queue scheduler
package mqs_pkg;
  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int NUM_LEVELS      = 4;
  localparam int ID_W            = 8;
  localparam int LVL_W           = 3;
  localparam int TIME_W          = 16;
  localparam int TICK_W          = 4;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 4;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PARTIAL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROUND_END = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 4'd1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic [TICK_W-1:0] QUANTUM_RST = 4'd4;
  localparam logic [TICK_W-1:0] BUDGET_RST  = 4'd15;

  typedef struct packed {
    logic              opcode;
    logic              bad;     // level out of range or zero burst
    logic [ID_W-1:0]   job_id;
    logic [LVL_W-1:0]  level;
    logic [TIME_W-1:0] burst;
  } cmd_t;
endpackage

// File: src/mqs_front.sv
// front end: takes input transfers, classifies them and queues commands
module mqs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,
  input  logic                s_tuser,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output mqs_pkg::cmd_t       cmd
);
  mqs_pkg::cmd_t ent [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  mqs_pkg::cmd_t in_cmd;
  logic push, pop;

  always_comb begin
    in_cmd.opcode = s_tuser;
    in_cmd.job_id = s_tdata[7:0];
    in_cmd.level  = s_tdata[10:8];
    in_cmd.burst  = s_tdata[26:11];
    in_cmd.bad    = (s_tdata[10:8] > 3'd3) || (s_tdata[26:11] == 16'd0);
  end

  assign s_tready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = ent[rptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= in_cmd;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: src/mqs_back.sv
// back end: job memory, level walk and event output register
`include "multilevel_queue_scheduler_assert.svh"
module mqs_back #(
  parameter int QUEUE_DEPTH = mqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          quantum,
  input  logic [3:0]          level_budget,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  mqs_pkg::cmd_t       cmd,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);
  localparam int D   = QUEUE_DEPTH;
  localparam int AW  = (D > 1) ? $clog2(D) : 1;
  localparam int CW  = $clog2(D + 1);
  localparam int MD  = mqs_pkg::NUM_LEVELS * D;
  localparam int MAW = $clog2(MD);
  localparam int EW  = mqs_pkg::ID_W + mqs_pkg::TIME_W;
  localparam logic [CW:0]   DW   = (CW+1)'(D);
  localparam logic [CW-1:0] FULL = CW'(D);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_LSTART, S_LOOP, S_SCRD, S_SCCMP, S_SHCHK, S_SHWR, S_DISP, S_END
  } state_t;

  state_t state;
  mqs_pkg::cmd_t cur;
  logic [1:0]    lv;
  logic [3:0]    b;
  logic [CW-1:0] k, best;
  logic [7:0]    best_id;
  logic [15:0]   best_rem;
  logic [AW-1:0] head [mqs_pkg::NUM_LEVELS];
  logic [CW-1:0] cnt  [mqs_pkg::NUM_LEVELS];

  logic [EW-1:0] mem [MD];
  logic [EW-1:0] rdata;
  logic          rd_en, wr_en;
  logic [MAW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= DW) ? s - DW : s;
    return t[AW-1:0];
  endfunction

  function automatic logic [MAW-1:0] maddr(input logic [1:0] l, input logic [AW-1:0] sl);
    return MAW'(l) * MAW'(D) + MAW'(sl);
  endfunction

  logic can_emit, reject, sjf, fire;
  logic [CW-1:0] cur_cnt;
  logic [AW-1:0] cur_head;
  assign can_emit = !m_tvalid || m_tready;
  assign cur_cnt  = cnt[lv];
  assign cur_head = head[lv];
  assign sjf      = (lv == 2'd1) || (lv == 2'd2);
  assign reject   = cur.bad || (cnt[cur.level[1:0]] == FULL);
  assign cmd_ready = (state == S_IDLE);
  // an event is loaded into the output register this cycle
  assign fire     = can_emit && (state == S_ADD || state == S_DISP || state == S_END);

  // dispatch of one job
  logic [7:0]  src_id;
  logic [15:0] src_rem, rem16, b16, qt16;
  logic [3:0]  qt;
  logic [2:0]  d_kind;
  logic [3:0]  d_used, d_b;
  logic [15:0] d_left;
  logic        d_pop, d_push, d_whead;

  always_comb begin
    src_id  = sjf ? best_id  : rdata[EW-1:mqs_pkg::TIME_W];
    src_rem = sjf ? best_rem : rdata[mqs_pkg::TIME_W-1:0];
    qt      = (quantum == 4'd0) ? 4'd1 : quantum;
    rem16   = src_rem;
    b16     = {12'd0, b};
    qt16    = {12'd0, qt};
    d_kind  = mqs_pkg::KIND_DONE;
    d_used  = src_rem[3:0];
    d_left  = 16'd0;
    d_pop   = 1'b0;
    d_push  = 1'b0;
    d_whead = 1'b0;
    d_b     = b;
    case (lv)
      2'd0: begin
        if (b >= qt) begin
          d_pop = 1'b1;
          if (rem16 >= qt16) begin
            d_b    = b - qt;
            d_used = qt;
            d_left = rem16 - qt16;
            if (rem16 != qt16) begin
              d_kind = mqs_pkg::KIND_PARTIAL;
              d_push = 1'b1;
            end
          end else begin
            d_b = b - src_rem[3:0];
          end
        end else if (rem16 <= b16) begin
          d_b   = b - src_rem[3:0];
          d_pop = 1'b1;
        end else begin
          d_kind  = mqs_pkg::KIND_PARTIAL;
          d_used  = b;
          d_left  = rem16 - b16;
          d_whead = 1'b1;
          d_b     = 4'd0;
        end
      end
      2'd3: begin
        if (rem16 > b16) begin
          d_kind  = mqs_pkg::KIND_PARTIAL;
          d_used  = b;
          d_left  = rem16 - b16;
          d_whead = 1'b1;
          d_b     = 4'd0;
        end else begin
          d_b   = b - src_rem[3:0];
          d_pop = 1'b1;
        end
      end
      default: begin
        if (rem16 >= b16) begin
          d_used = b;
          d_left = rem16 - b16;
          d_b    = 4'd0;
          if (rem16 != b16) begin
            d_kind = mqs_pkg::KIND_PARTIAL;
            d_push = 1'b1;
          end
        end else begin
          d_b = b - src_rem[3:0];
        end
      end
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = maddr(lv, cur_head);
    wr_en   = 1'b0;
    wr_addr = maddr(lv, cur_head);
    wr_data = {src_id, d_left};
    unique case (state)
      S_ADD: begin
        wr_en   = can_emit && !reject;
        wr_addr = maddr(cur.level[1:0],
                        wrap({1'b0, CW'(head[cur.level[1:0]])} + {1'b0, cnt[cur.level[1:0]]}));
        wr_data = {cur.job_id, cur.burst};
      end
      S_LOOP: begin
        rd_en = (b != 4'd0) && (cur_cnt != '0) && !sjf;
      end
      S_SCRD: begin
        rd_en   = 1'b1;
        rd_addr = maddr(lv, wrap({1'b0, CW'(cur_head)} + {1'b0, k}));
      end
      S_SHCHK: begin
        rd_en   = 1'b1;
        rd_addr = maddr(lv, wrap({1'b0, CW'(cur_head)} + {1'b0, k} + (CW+1)'(1)));
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = maddr(lv, wrap({1'b0, CW'(cur_head)} + {1'b0, k}));
        wr_data = rdata;
      end
      S_DISP: begin
        wr_en = can_emit && (d_push || d_whead);
        if (d_push) wr_addr = maddr(lv, wrap({1'b0, CW'(cur_head)} + {1'b0, cur_cnt}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  logic [CW-1:0] k_inc;
  logic          take;
  assign k_inc = k + CW'(1);
  assign take  = (k == '0) || (rdata[mqs_pkg::TIME_W-1:0] < best_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      lv       <= 2'd0;
      for (int i = 0; i < mqs_pkg::NUM_LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            lv    <= 2'd0;
            state <= (cmd.opcode == mqs_pkg::OP_ADD) ? S_ADD : S_LSTART;
          end
        end
        S_ADD: begin
          if (can_emit) begin
            m_tlast  <= 1'b1;
            m_tdata  <= {2'd0, cur.burst, 4'd0,
                         reject ? 2'd0 : cur.level[1:0], cur.job_id};
            m_tuser  <= reject ? mqs_pkg::KIND_REJECTED : mqs_pkg::KIND_ADDED;
            if (!reject) cnt[cur.level[1:0]] <= cnt[cur.level[1:0]] + CW'(1);
            state <= S_IDLE;
          end
        end
        S_LSTART: begin
          b     <= level_budget;
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (b == 4'd0 || cur_cnt == '0) begin
            if (lv == 2'd3) state <= S_END;
            else begin
              lv    <= lv + 2'd1;
              state <= S_LSTART;
            end
          end else if (sjf) begin
            k     <= '0;
            state <= S_SCRD;
          end else begin
            state <= S_DISP;
          end
        end
        S_SCRD: state <= S_SCCMP;
        S_SCCMP: begin
          if (take) begin
            best     <= k;
            best_id  <= rdata[EW-1:mqs_pkg::TIME_W];
            best_rem <= rdata[mqs_pkg::TIME_W-1:0];
          end
          if (k_inc == cur_cnt) begin
            k     <= take ? k : best;
            state <= S_SHCHK;
          end else begin
            k     <= k_inc;
            state <= S_SCRD;
          end
        end
        S_SHCHK: begin
          // close the gap left by the chosen entry
          if (k_inc < cur_cnt) state <= S_SHWR;
          else begin
            cnt[lv] <= cur_cnt - CW'(1);
            state   <= S_DISP;
          end
        end
        S_SHWR: begin
          k     <= k_inc;
          state <= S_SHCHK;
        end
        S_DISP: begin
          if (can_emit) begin
            m_tlast  <= 1'b0;
            m_tdata  <= {2'd0, d_left, d_used, lv, src_id};
            m_tuser  <= d_kind;
            b        <= d_b;
            if (d_pop) head[lv] <= wrap({1'b0, CW'(cur_head)} + (CW+1)'(1));
            if (d_pop && !d_push) cnt[lv] <= cur_cnt - CW'(1);
            if (d_push && !d_pop) cnt[lv] <= cur_cnt + CW'(1);
            state <= S_LOOP;
          end
        end
        S_END: begin
          if (can_emit) begin
            m_tlast  <= 1'b1;
            m_tdata  <= 32'd0;
            m_tuser  <= mqs_pkg::KIND_ROUND_END;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MQS_ASSERT(a_cnt_max, clk, rst, cur_cnt <= FULL)
  `MQS_ASSERT(a_end_last, clk, rst, (m_tvalid && m_tuser == mqs_pkg::KIND_ROUND_END) |-> m_tlast)
  `MQS_ASSERT(a_disp_hold, clk, rst, (state == S_DISP && !can_emit) |=> state == S_DISP)
  `MQS_ASSERT(a_idle_nowr, clk, rst, state == S_IDLE |-> !wr_en)
endmodule

// File: src/multilevel_queue_scheduler.sv
// top level of the multilevel queue scheduler
// Four job queues share one job memory. An add transfer gives one event, loaded into the
// output register in the add state once the command leaves the two-entry command queue.
// A run transfer walks levels 0 to 3: a state loads each level's budget and a state tests
// it; at levels 0 and 3 the memory is read at the test, then the job is dispatched; at
// levels 1 and 2 the test leads to the shortest-job search (a read and a compare per
// queued job), the shift that closes the gap (a check and a write per entry moved, and a
// last check to end it), then the dispatch; the round end event comes last. A stalled
// output holds the walk. Configuration writes are always ready.
module multilevel_queue_scheduler #(
  parameter int QUEUE_DEPTH = mqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // job_id[7:0], level[10:8], burst[26:11]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_job_id[7:0], out_level[9:8], time_used[13:10],
                                 // time_left[29:14]
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  logic [3:0] quantum, level_budget;
  logic cmd_valid, cmd_ready;
  mqs_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum      <= mqs_pkg::QUANTUM_RST;
      level_budget <= mqs_pkg::BUDGET_RST;
    end else if (cfg_valid) begin
      if (cfg_index == mqs_pkg::CFG_QUANTUM) quantum <= cfg_data;
      if (cfg_index == mqs_pkg::CFG_BUDGET)  level_budget <= cfg_data;
    end
  end

  mqs_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .cmd_valid, .cmd_ready, .cmd
  );

  mqs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .quantum, .level_budget, .cmd_valid, .cmd_ready, .cmd,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );
endmodule
